>>> sv/pcg32_random_with_bounded_draws_macros.svh
// Assertion macros shared by the generator RTL.
`ifndef PCG32_RANDOM_WITH_BOUNDED_DRAWS_MACROS_SVH
`define PCG32_RANDOM_WITH_BOUNDED_DRAWS_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define PCG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define PCG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/pcg_pkg.sv
// Types, constants and helper functions of the PCG32 generator.
`timescale 1ns / 1ps
package pcg_pkg;
	localparam logic [63:0] PcgMult      = 64'h5851F42D4C957F2D;
	localparam logic [63:0] SeedReset    = 64'd42;
	localparam logic [63:0] StreamReset  = 64'd54;
	// State and increment seeded before the final step of a reset reseed.
	localparam logic [63:0] IncReset     = 64'd109;
	localparam logic [63:0] StatePreStep = 64'd151;

	localparam logic [2:0] ACT_RAW32  = 3'd0;
	localparam logic [2:0] ACT_RAW64  = 3'd1;
	localparam logic [2:0] ACT_BELOW  = 3'd2;
	localparam logic [2:0] ACT_SRANGE = 3'd3;
	localparam logic [2:0] ACT_FRANGE = 3'd4;
	localparam logic [2:0] ACT_CHANCE = 3'd5;
	localparam logic [2:0] ACT_RESEED = 3'd6;

	localparam logic CFG_SEED   = 1'b0;
	localparam logic CFG_STREAM = 1'b1;

	// Work kinds after decode.
	localparam logic [2:0] K_FIXED  = 3'd0;
	localparam logic [2:0] K_RAW    = 3'd1;
	localparam logic [2:0] K_RAW64  = 3'd2;
	localparam logic [2:0] K_BELOW  = 3'd3;
	localparam logic [2:0] K_CHANCE = 3'd4;
	localparam logic [2:0] K_RESEED = 3'd5;
	localparam logic [2:0] K_INIT   = 3'd6;

	typedef struct packed {
		logic capture;
		logic reseed;
		logic mul_a;
		logic mul_b;
		logic mul_c;
		logic adv;
		logic save_hi;
		logic mul_l;
		logic div_step;
		logic div_first;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       lo_lt_b;
		logic       lo_lt_t;
	} stat_t;

	// XSH-RR output permutation.
	function automatic logic [31:0] permute(input logic [63:0] s);
		logic [63:0] xs;
		logic [31:0] x;
		logic [63:0] dbl;
		xs  = (s >> 18) ^ s;
		x   = xs[58:27];
		dbl = {x, x} >> s[63:59];
		return dbl[31:0];
	endfunction
endpackage

>>> sv/pcg_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface pcg_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [31:0]        bound;
	logic signed [31:0] range_low;
	logic signed [31:0] range_high;
	logic signed [31:0] probability;
	modport source (output valid, action, bound, range_low, range_high, probability,
		input ready);
	modport sink (input valid, action, bound, range_low, range_high, probability,
		output ready);
endinterface

interface pcg_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	modport source (output valid, value, input ready);
	modport sink (input valid, value, output ready);
endinterface

>>> sv/pcg_dp.sv
// Datapath: LCG state, shared 32x32 multiplier, threshold divider, result register.
`timescale 1ns / 1ps
`include "pcg32_random_with_bounded_draws_macros.svh"
module pcg_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pcg_pkg::cmd_t      cmd,
	output pcg_pkg::stat_t     stat,
	input  logic [2:0]         action,
	input  logic [31:0]        bound,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	input  logic signed [31:0] probability,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [63:0]        cfg_wdata,
	output logic [63:0]        value
);
	logic [63:0] state_q, inc_q, seed_q, stream_q;
	logic [2:0]  kind_q;
	logic [31:0] bnd_q, base_q, draw_q, hi_q, cross_q;
	logic [15:0] prob_q;
	logic [63:0] fix_q, p0_q, prod_q, value_q;
	logic [32:0] rem_q;

	logic [2:0]         kind_d;
	logic [31:0]        bnd_d, base_d;
	logic [63:0]        fix_d;
	logic signed [32:0] diff, span;
	logic [31:0]        mul_x, mul_y;
	logic [63:0]        mul_p;
	logic [32:0]        rem_sh;
	logic [63:0]        new_inc;

	// Decode the request into a work kind, bound and base.
	always_comb begin
		diff   = 33'(range_high) - 33'(range_low);
		span   = diff + 33'sd1;
		kind_d = pcg_pkg::K_FIXED;
		bnd_d  = bound;
		base_d = '0;
		fix_d  = '0;
		case (action)
			pcg_pkg::ACT_RAW32: kind_d = pcg_pkg::K_RAW;
			pcg_pkg::ACT_RAW64: kind_d = pcg_pkg::K_RAW64;
			pcg_pkg::ACT_BELOW: begin
				if (bound != '0) kind_d = pcg_pkg::K_BELOW;
			end
			pcg_pkg::ACT_SRANGE: begin
				base_d = range_low;
				fix_d  = {32'd0, range_low};
				if (!diff[32]) begin
					kind_d = span[32] ? pcg_pkg::K_RAW : pcg_pkg::K_BELOW;
					bnd_d  = span[31:0];
				end
			end
			pcg_pkg::ACT_FRANGE: begin
				base_d = range_low;
				fix_d  = {32'd0, range_low};
				if (!diff[32] && diff != '0) begin
					kind_d = pcg_pkg::K_BELOW;
					bnd_d  = diff[31:0];
				end
			end
			pcg_pkg::ACT_CHANCE: begin
				if (probability <= 0) fix_d = 64'd0;
				else if (probability >= 32'sd65536) fix_d = 64'd1;
				else kind_d = pcg_pkg::K_CHANCE;
			end
			pcg_pkg::ACT_RESEED: kind_d = pcg_pkg::K_RESEED;
			default: kind_d = pcg_pkg::K_FIXED;
		endcase
	end

	// One shared multiplier, operands picked by the active step.
	always_comb begin
		mul_x = state_q[31:0];
		mul_y = pcg_pkg::PcgMult[31:0];
		if (cmd.mul_b) mul_y = pcg_pkg::PcgMult[63:32];
		if (cmd.mul_c) mul_x = state_q[63:32];
		if (cmd.mul_l) begin
			mul_x = draw_q;
			mul_y = bnd_q;
		end
		mul_p = 64'(mul_x) * 64'(mul_y);
	end

	assign rem_sh  = cmd.div_first ? 33'd1 : {rem_q[31:0], 1'b0};
	assign new_inc = {stream_q[62:0], 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcg_pkg::StatePreStep;
			inc_q    <= pcg_pkg::IncReset;
			seed_q   <= pcg_pkg::SeedReset;
			stream_q <= pcg_pkg::StreamReset;
			kind_q   <= pcg_pkg::K_INIT;
		end else begin
			if (cfg_we && cfg_index == pcg_pkg::CFG_SEED) seed_q <= cfg_wdata;
			if (cfg_we && cfg_index == pcg_pkg::CFG_STREAM) stream_q <= cfg_wdata;
			if (cmd.capture) kind_q <= kind_d;
			if (cmd.reseed) begin
				inc_q   <= new_inc;
				state_q <= new_inc + seed_q;
			end
			if (cmd.adv) state_q <= p0_q + {cross_q, 32'd0} + inc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bnd_q  <= bnd_d;
			base_q <= base_d;
			fix_q  <= fix_d;
			prob_q <= probability[15:0];
		end
		if (cmd.mul_a) p0_q <= mul_p;
		if (cmd.mul_b) cross_q <= mul_p[31:0];
		if (cmd.mul_c) cross_q <= cross_q + mul_p[31:0];
		if (cmd.adv) draw_q <= pcg_pkg::permute(state_q);
		if (cmd.save_hi) hi_q <= draw_q;
		if (cmd.mul_l) prod_q <= mul_p;
		if (cmd.div_step) rem_q <= (rem_sh >= 33'(bnd_q)) ? rem_sh - 33'(bnd_q) : rem_sh;
		if (cmd.load_out) begin
			case (kind_q)
				pcg_pkg::K_RAW:    value_q <= {32'd0, base_q + draw_q};
				pcg_pkg::K_RAW64:  value_q <= {hi_q, draw_q};
				pcg_pkg::K_BELOW:  value_q <= {32'd0, base_q + prod_q[63:32]};
				pcg_pkg::K_CHANCE: value_q <= {63'd0, draw_q[31:16] < prob_q};
				pcg_pkg::K_FIXED:  value_q <= fix_q;
				default:           value_q <= '0;
			endcase
		end
	end

	assign stat.kind    = kind_q;
	assign stat.lo_lt_b = prod_q[31:0] < bnd_q;
	assign stat.lo_lt_t = prod_q[31:0] < rem_q[31:0];
	assign value        = value_q;

	`PCG_ASSERT_NEXT(a_reseed_inc_odd, cmd.reseed, inc_q[0], "increment not odd after reseed")
	`PCG_ASSERT_NOW(a_div_rem_below, cmd.div_step && !cmd.div_first, rem_q < 33'(bnd_q), "remainder not below bound")
	`PCG_ASSERT_NOW(a_mul_one_hot, 1'b1, $onehot0({cmd.mul_a, cmd.mul_b, cmd.mul_c, cmd.mul_l}), "multiplier claimed twice")
endmodule

>>> sv/pcg_ctrl.sv
// Controller: sequences draws, bounded-draw checks and the threshold division.
`timescale 1ns / 1ps
`include "pcg32_random_with_bounded_draws_macros.svh"
module pcg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pcg_pkg::stat_t stat,
	output pcg_pkg::cmd_t  cmd
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RS   = 4'd2;
	localparam logic [3:0] S_MA   = 4'd3;
	localparam logic [3:0] S_MB   = 4'd4;
	localparam logic [3:0] S_MC   = 4'd5;
	localparam logic [3:0] S_ADV  = 4'd6;
	localparam logic [3:0] S_POST = 4'd7;
	localparam logic [3:0] S_ML   = 4'd8;
	localparam logic [3:0] S_CHK  = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q, state_d;
	logic [5:0] cnt_q;
	logic       second_q, thr_ok_q, out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				case (stat.kind)
					pcg_pkg::K_FIXED:  state_d = S_FIN;
					pcg_pkg::K_RESEED: state_d = S_RS;
					default:           state_d = S_MA;
				endcase
			end
			S_RS: begin
				cmd.reseed = 1'b1;
				state_d    = S_MA;
			end
			S_MA: begin
				cmd.mul_a = 1'b1;
				state_d   = S_MB;
			end
			S_MB: begin
				cmd.mul_b = 1'b1;
				state_d   = S_MC;
			end
			S_MC: begin
				cmd.mul_c = 1'b1;
				state_d   = S_ADV;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = S_POST;
			end
			S_POST: begin
				case (stat.kind)
					pcg_pkg::K_INIT:  state_d = S_IDLE;
					pcg_pkg::K_BELOW: state_d = S_ML;
					pcg_pkg::K_RAW64: begin
						cmd.save_hi = !second_q;
						state_d     = second_q ? S_FIN : S_MA;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_ML: begin
				cmd.mul_l = 1'b1;
				state_d   = S_CHK;
			end
			S_CHK: begin
				if (!stat.lo_lt_b) state_d = S_FIN;
				else if (!thr_ok_q) state_d = S_DIV;
				else if (stat.lo_lt_t) state_d = S_MA;
				else state_d = S_FIN;
			end
			S_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.div_first = (cnt_q == '0);
				if (cnt_q == 6'd32) state_d = S_CHK;
			end
			S_FIN: begin
				cmd.load_out = slot_free;
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_MA;
			cnt_q       <= '0;
			second_q    <= 1'b0;
			thr_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) begin
				second_q <= 1'b0;
				thr_ok_q <= 1'b0;
			end
			if (cmd.save_hi) second_q <= 1'b1;
			// Count division steps; mark the threshold ready on the last one.
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd32) begin
					thr_ok_q <= 1'b1;
					cnt_q    <= '0;
				end
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`PCG_ASSERT_NOW(a_div_count, state_q == S_DIV, cnt_q <= 6'd32, "division ran past 33 steps")
	`PCG_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready, out_valid_q, "result dropped before taken")
	`PCG_ASSERT_NEXT(a_fin_loads, state_q == S_FIN && slot_free, out_valid_q && state_q == S_IDLE, "result not posted")
	`PCG_ASSERT_NOW(a_redraw_needs_thr, state_q == S_CHK && state_d == S_MA, thr_ok_q, "redraw without threshold")
endmodule

>>> sv/pcg32_random_with_bounded_draws.sv
// Top level of the PCG32 generator with bounded draws.
`timescale 1ns / 1ps
// PCG32 (XSH-RR) generator taking one request transaction at a time and giving one response
// transaction per request. Every draw runs the 64-bit LCG step through a single shared 32x32
// multiplier in three partial products plus an add step. Decode and result posting are steps
// of their own; a 64-bit draw runs two draws, and a request answered without a draw (zero
// bound, malformed range, chance at its limits, unused action) needs only those. Bounded draws
// add a bound multiply and check; when the low product word falls below the bound, the
// rejection threshold 2^32 mod bound is found by a restoring divider, once per request,
// followed by one more check, and each rejected draw runs another draw. A reseed loads the
// increment and state from the stream and seed registers before its draw. After reset the
// block finishes the seeding step and accepts no request meanwhile; configuration writes
// are taken at any time. Registers: index 0 seed, index 1 stream; writes take effect at the
// next reseed. The response register holds a finished result while the next request is taken.
module pcg32_random_with_bounded_draws (
	input  logic           clk,
	input  logic           arst_n,
	pcg_req_if.sink        req,
	pcg_rsp_if.source      rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [63:0]    cfg_wdata
);
	pcg_pkg::cmd_t  cmd;
	pcg_pkg::stat_t stat;

	// Sequence each transaction through the draw and check steps.
	pcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold generator state and do the arithmetic.
	pcg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (req.action),
		.bound       (req.bound),
		.range_low   (req.range_low),
		.range_high  (req.range_high),
		.probability (req.probability),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.value       (rsp.value)
	);
endmodule
